[sv/aid_pkg.sv]
package aid_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_W     = 5;
    localparam int OPND_W    = 24;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 72;

    // Translation classes
    localparam logic [2:0] CLS_NONE     = 3'd0;
    localparam logic [2:0] CLS_NORMAL   = 3'd1;
    localparam logic [2:0] CLS_INDIRECT = 3'd2;
    localparam logic [2:0] CLS_BRANCH   = 3'd3;
    localparam logic [2:0] CLS_EXCEPT   = 3'd4;

    // Decoded forms
    localparam logic [3:0] KIND_DPREG = 4'd0;
    localparam logic [3:0] KIND_DPIMM = 4'd1;
    localparam logic [3:0] KIND_MUL   = 4'd2;
    localparam logic [3:0] KIND_MULL  = 4'd3;
    localparam logic [3:0] KIND_SWP   = 4'd4;
    localparam logic [3:0] KIND_PSR   = 4'd5;
    localparam logic [3:0] KIND_UNDEF = 4'd6;
    localparam logic [3:0] KIND_LDST  = 4'd7;
    localparam logic [3:0] KIND_LDM   = 4'd8;
    localparam logic [3:0] KIND_B     = 4'd9;
    localparam logic [3:0] KIND_COP   = 4'd10;
    localparam logic [3:0] KIND_SWI   = 4'd11;
    localparam logic [3:0] KIND_HIGH  = 4'd12;

    // Major opcodes, bits 27:25
    localparam logic [2:0] MAJ_DP_REG  = 3'd0;
    localparam logic [2:0] MAJ_DP_IMM  = 3'd1;
    localparam logic [2:0] MAJ_LDST_IMM = 3'd2;
    localparam logic [2:0] MAJ_LDST_REG = 3'd3;
    localparam logic [2:0] MAJ_LDM     = 3'd4;
    localparam logic [2:0] MAJ_BRANCH  = 3'd5;
    localparam logic [2:0] MAJ_COP_LS  = 3'd6;
    localparam logic [2:0] MAJ_COP_SWI = 3'd7;

    // ALU opcodes with restricted register fields
    localparam logic [3:0] ALU_MOV = 4'd13;
    localparam logic [3:0] ALU_MVN = 4'd15;

    // Positions in flag_bits
    localparam int F_P = 0;
    localparam int F_U = 1;
    localparam int F_B = 2;
    localparam int F_W = 3;
    localparam int F_L = 4;
    localparam int F_S = 5;
    localparam int F_A = 6;

    localparam logic [REG_W-1:0] REG_NA = 5'd16;
    localparam logic [3:0]       REG_PC = 4'd15;

    localparam logic [WORD_W-1:0] MSR_REG_MASK  = 32'h0fb0fff0;
    localparam logic [WORD_W-1:0] MSR_REG_MATCH = 32'h0120f000;
    localparam logic [WORD_W-1:0] MRS_MASK      = 32'h0fbf0fff;
    localparam logic [WORD_W-1:0] MRS_MATCH     = 32'h010f0000;
    localparam logic [WORD_W-1:0] UNDEF_MASK    = 32'h0f000090;
    localparam logic [WORD_W-1:0] UNDEF_MATCH   = 32'h01000090;
    localparam logic [WORD_W-1:0] MSR_IMM_MASK  = 32'h0fb0f000;
    localparam logic [WORD_W-1:0] MSR_IMM_MATCH = 32'h0320f000;
    localparam logic [WORD_W-1:0] HIGH_VEC_BASE = 32'hffff0000;

    typedef struct packed {
        logic [OPND_W-1:0] operand_bits;
        logic [REG_W-1:0]  reg_shift;
        logic [REG_W-1:0]  reg_second;
        logic [REG_W-1:0]  reg_dest;
        logic [REG_W-1:0]  reg_first;
        logic [6:0]        flag_bits;
        logic [3:0]        alu_op;
        logic [3:0]        sub_kind;
        logic [2:0]        major_op;
        logic [3:0]        cond_code;
        logic              decode_error;
        logic [2:0]        insn_class;
    } dec_res_t;

    localparam int RES_W = $bits(dec_res_t);

endpackage

[sv/aid_decode.sv]
module aid_decode
    import aid_pkg::*;
(
    input  logic [WORD_W-1:0] instruction,
    input  logic [WORD_W-1:0] fetch_address,
    output dec_res_t          res
);

    logic [WORD_W-1:0] w;
    logic [3:0]        rn;
    logic [3:0]        rd;
    logic [3:0]        rs;
    logic [3:0]        rm;
    logic [3:0]        alu;
    logic              dp_bad;
    logic              mul_bad;
    logic              mull_bad;
    logic              any_pc;
    logic [6:0]        pubwl;

    assign w      = instruction;
    assign rn     = w[19:16];
    assign rd     = w[15:12];
    assign rs     = w[11:8];
    assign rm     = w[3:0];
    assign alu    = w[24:21];
    // Compares must leave Rd zero; MOV and MVN must leave Rn zero.
    assign dp_bad = ((alu[3:2] == 2'b10) && (rd != 4'd0)) ||
                    (((alu == ALU_MOV) || (alu == ALU_MVN)) && (rn != 4'd0));
    assign any_pc = (rn == REG_PC) || (rd == REG_PC) || (rs == REG_PC) || (rm == REG_PC);
    assign mul_bad  = (rn == rm) || any_pc;
    assign mull_bad = (rn == rm) || (rn == rd) || (rd == rm) || any_pc;
    assign pubwl  = {2'b00, w[20], w[21], w[22], w[23], w[24]};

    always_comb
    begin
        res              = '0;
        res.reg_first    = REG_NA;
        res.reg_dest     = REG_NA;
        res.reg_second   = REG_NA;
        res.reg_shift    = REG_NA;
        res.insn_class   = CLS_NONE;

        if (fetch_address > HIGH_VEC_BASE)
        begin
            res.insn_class = CLS_EXCEPT;
            res.sub_kind   = KIND_HIGH;
        end
        else
        begin
            res.cond_code = w[31:28];
            res.major_op  = w[27:25];
            case (w[27:25])
                MAJ_DP_REG:
                begin
                    if ((w[7:4] == 4'd9) && (w[26:23] == 4'd1))
                    begin
                        res.sub_kind        = KIND_MULL;
                        res.flag_bits[F_A]  = w[21];
                        res.flag_bits[F_S]  = w[20];
                        res.flag_bits[F_U]  = w[22];
                        res.reg_dest        = {1'b0, rn};
                        res.reg_first       = {1'b0, rd};
                        res.reg_shift       = {1'b0, rs};
                        res.reg_second      = {1'b0, rm};
                        res.decode_error    = mull_bad;
                        res.insn_class      = mull_bad ? CLS_NONE : CLS_NORMAL;
                    end
                    else if ((w[7:4] == 4'd9) && (w[26:22] == 5'd0))
                    begin
                        res.sub_kind        = KIND_MUL;
                        res.flag_bits[F_A]  = w[21];
                        res.flag_bits[F_S]  = w[20];
                        res.reg_dest        = {1'b0, rn};
                        res.reg_first       = {1'b0, rd};
                        res.reg_shift       = {1'b0, rs};
                        res.reg_second      = {1'b0, rm};
                        res.decode_error    = mul_bad;
                        res.insn_class      = mul_bad ? CLS_NONE : CLS_NORMAL;
                    end
                    else if ((w[11:4] == 8'd9) && (w[21:20] == 2'd0) &&
                             (w[27:23] == 5'd2))
                    begin
                        res.sub_kind       = KIND_SWP;
                        res.flag_bits[F_B] = w[22];
                        res.reg_first      = {1'b0, rn};
                        res.reg_dest       = {1'b0, rd};
                        res.reg_second     = {1'b0, rm};
                        res.insn_class     = CLS_NORMAL;
                    end
                    else if (((w & MSR_REG_MASK) == MSR_REG_MATCH) ||
                             ((w & MRS_MASK) == MRS_MATCH))
                    begin
                        res.sub_kind   = KIND_PSR;
                        res.insn_class = CLS_EXCEPT;
                    end
                    else if ((w & UNDEF_MASK) == UNDEF_MATCH)
                    begin
                        res.sub_kind = KIND_UNDEF;
                    end
                    else
                    begin
                        res.sub_kind       = KIND_DPREG;
                        res.alu_op         = alu;
                        res.flag_bits[F_S] = w[20];
                        res.reg_first      = {1'b0, rn};
                        res.reg_dest       = {1'b0, rd};
                        res.reg_second     = {1'b0, rm};
                        res.operand_bits   = {16'd0, w[11:4]};
                        if (dp_bad)
                        begin
                            res.decode_error = 1'b1;
                        end
                        else if (w[4] && w[7])
                        begin
                            // Register-controlled shift with bit 7 set is malformed.
                            res.decode_error = 1'b1;
                            res.insn_class   = CLS_NORMAL;
                        end
                        else
                        begin
                            res.insn_class = (rd == REG_PC) ? CLS_INDIRECT : CLS_NORMAL;
                        end
                    end
                end
                MAJ_DP_IMM:
                begin
                    if ((w & MSR_IMM_MASK) == MSR_IMM_MATCH)
                    begin
                        res.sub_kind   = KIND_PSR;
                        res.insn_class = CLS_EXCEPT;
                    end
                    else
                    begin
                        res.sub_kind       = KIND_DPIMM;
                        res.alu_op         = alu;
                        res.flag_bits[F_S] = w[20];
                        res.reg_first      = {1'b0, rn};
                        res.reg_dest       = {1'b0, rd};
                        res.operand_bits   = {12'd0, w[11:0]};
                        if (dp_bad)
                        begin
                            res.decode_error = 1'b1;
                        end
                        else
                        begin
                            res.insn_class = (rd == REG_PC) ? CLS_INDIRECT : CLS_NORMAL;
                        end
                    end
                end
                MAJ_LDST_IMM:
                begin
                    res.sub_kind     = KIND_LDST;
                    res.flag_bits    = pubwl;
                    res.reg_first    = {1'b0, rn};
                    res.reg_dest     = {1'b0, rd};
                    res.operand_bits = {12'd0, w[11:0]};
                    res.insn_class   = (rd == REG_PC) ? CLS_INDIRECT : CLS_NORMAL;
                end
                MAJ_LDST_REG:
                begin
                    if (w[4])
                    begin
                        res.sub_kind     = KIND_UNDEF;
                        res.decode_error = 1'b1;
                    end
                    else
                    begin
                        res.sub_kind     = KIND_LDST;
                        res.flag_bits    = pubwl;
                        res.reg_first    = {1'b0, rn};
                        res.reg_dest     = {1'b0, rd};
                        res.reg_second   = {1'b0, rm};
                        res.operand_bits = {16'd0, w[11:4]};
                        res.insn_class   = (rd == REG_PC) ? CLS_INDIRECT : CLS_NORMAL;
                    end
                end
                MAJ_LDM:
                begin
                    res.sub_kind     = KIND_LDM;
                    res.flag_bits    = pubwl;
                    res.reg_first    = {1'b0, rn};
                    res.operand_bits = {8'd0, w[15:0]};
                    res.insn_class   = w[15] ? CLS_INDIRECT : CLS_NORMAL;
                end
                MAJ_BRANCH:
                begin
                    res.sub_kind       = KIND_B;
                    res.flag_bits[F_L] = w[24];
                    res.operand_bits   = w[23:0];
                    res.insn_class     = CLS_BRANCH;
                end
                MAJ_COP_LS:
                begin
                    res.sub_kind   = KIND_COP;
                    res.insn_class = CLS_EXCEPT;
                end
                MAJ_COP_SWI:
                begin
                    res.insn_class = CLS_EXCEPT;
                    if (w[24])
                    begin
                        res.sub_kind = KIND_SWI;
                    end
                    else
                    begin
                        res.sub_kind = KIND_COP;
                        // Only the data operation form carries its register fields.
                        if (!w[4])
                        begin
                            res.reg_first    = {1'b0, rn};
                            res.reg_dest     = {1'b0, rd};
                            res.reg_second   = {1'b0, rm};
                            res.operand_bits = w[23:0];
                        end
                    end
                end
                default:
                begin
                    res.sub_kind = KIND_UNDEF;
                end
            endcase
        end
    end

endmodule

[sv/arm_instruction_decoder_core.sv]
// ARM v4 instruction decoder. Each request carries one instruction word and its
// fetch address and yields exactly one decoded result. The block is a two-register
// pipeline: the request is captured in an input register, decoded by a single pass of
// combinational logic, and held in a result register until taken. A new request is
// accepted every cycle while the result side keeps up, so throughput is one
// instruction per clock; the result becomes valid once its request has moved from the
// input register into the result register.
// When the result side stalls, both registers fill and further requests wait.
module arm_instruction_decoder_core
    import aid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] instruction, [63:32] fetch_address
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] insn_class, [3] decode_error, [7:4] cond_code, [10:8] major_op,
    // [14:11] sub_kind, [18:15] alu_op, [25:19] flag_bits, [30:26] reg_first,
    // [35:31] reg_dest, [40:36] reg_second, [45:41] reg_shift,
    // [69:46] operand_bits, [71:70] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] instr_reg;
    logic [WORD_W-1:0] addr_reg;
    logic              out_valid_reg;
    dec_res_t          res_reg;
    dec_res_t          res_next;
    logic              advance;

    // The result register can take a new value when it is empty or being emptied.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    aid_decode u_decode (
        .instruction   (instr_reg),
        .fetch_address (addr_reg),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            instr_reg <= s_axis_tdata[WORD_W-1:0];
            addr_reg  <= s_axis_tdata[2*WORD_W-1:WORD_W];
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, res_reg};

endmodule
